[hdl/olt_pkg.sv]
// Package with shared constants and types for the object list tile generator.
`timescale 1ns / 1ps

package olt_pkg;

  // Default size of the tile descriptor memory in bytes.
  localparam int DESC_MEM_BYTES_DEF = 16384;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] REG_FLIP_SCREEN = 3'd0;

  // Item kinds carried on the mode field.
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_OBJECT = 1'b1;

  // Descriptor word offset of the first column object (byte address 0x400).
  localparam logic [12:0] COLUMN_BASE_WORD = 13'h0200;

  // Mirror point for a flipped screen.
  localparam logic [7:0] FLIP_ORIGIN = 8'd248;

  // Top edge offsets: 256 minus the object height in pixels, wrapped to 8 bits.
  localparam logic [7:0] SPRITE_TOP = 8'd240;
  localparam logic [7:0] COLUMN_TOP = 8'd0;

  // Final tile count index of each object kind.
  localparam logic [5:0] SPRITE_LAST_TILE = 6'd3;
  localparam logic [5:0] COLUMN_LAST_TILE = 6'd63;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } olt_state_t;

endpackage

[hdl/olt_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module olt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/object_list_tile_generator.sv]
// Top level of the object list tile generator: descriptor memory and tile sequencer.
`timescale 1ns / 1ps
// A write item or an empty object is done at acceptance and leaves busy low. Any other object
// keeps busy high after acceptance until its last tile is issued (4 tiles for a sprite, 64 for a
// column), one descriptor word read per tile from the even/odd byte memory pair; the first tile
// reaches the result ports after the state register and the registered memory read, and tiles
// follow every cycle, with no stall. After reset a clearing pass zeroes all (DESC_MEM_BYTES+1)/2
// words of the descriptor memory, one word a cycle; busy stays high until it ends. Config writes are taken any time.

module object_list_tile_generator #(
  parameter int DESC_MEM_BYTES = olt_pkg::DESC_MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Command side.
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [13:0] mem_address,
  input  logic [7:0]  mem_data,
  input  logic [7:0]  obj_y,
  input  logic [7:0]  obj_code,
  input  logic [7:0]  obj_x,
  input  logic [7:0]  obj_attr,
  input  logic        frame_start,
  // Result side.
  output logic        result_valid,
  output logic [13:0] tile_code,
  output logic [3:0]  tile_color,
  output logic [7:0]  screen_x,
  output logic [7:0]  screen_y,
  output logic        tile_flipped,
  output logic        last
);

  import olt_pkg::*;

  localparam int HALF = (DESC_MEM_BYTES + 1) / 2;
  localparam int AW   = $clog2(HALF);

  olt_state_t state, state_next;

  logic          flip_screen;
  logic [8:0]    column_x;
  logic [8:0]    column_x_next;
  logic [AW-1:0] clr_cnt;
  logic [5:0]    tile_cnt;
  logic          is_column;
  logic [12:0]   base_word;
  logic [7:0]    top_y;
  logic [3:0]    attr_color;

  logic          rd_valid;
  logic          rd_last;
  logic          rd_xc;
  logic [4:0]    rd_yc;

  logic          accept;
  logic          obj_empty;
  logic          issue;
  logic          issue_last;
  logic [12:0]   tile_word;
  logic          wr_in_range;

  logic          ram_we_lo, ram_we_hi, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    desc_lo, desc_hi;
  logic [7:0]    x_raw, y_raw;

  // Configuration register access; pready is always high.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_screen <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_FLIP_SCREEN) begin
      flip_screen <= pwdata[0];
    end
  end
  assign prdata = (paddr == REG_FLIP_SCREEN) ? {31'd0, flip_screen} : 32'd0;

  // Item acceptance and object decode.
  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign obj_empty   = (obj_y == 8'd0) && (obj_code == 8'd0) && (obj_x == 8'd0)
                       && (obj_attr == 8'd0);
  assign wr_in_range = (32'(mem_address) < 32'(DESC_MEM_BYTES));

  // Running column position: cleared on a frame start, then loaded or stepped.
  always_comb begin
    column_x_next = frame_start ? 9'd0 : column_x;
    if (!obj_empty) begin
      if (obj_code[7] && obj_code[6]) begin
        column_x_next = 9'(column_x_next + 9'd16);
      end else begin
        column_x_next = {obj_attr[6], obj_x};
      end
    end
  end

  // Word address of the current tile: base plus column and row offsets.
  assign tile_word  = is_column ? 13'(base_word + {7'd0, tile_cnt})
                                : 13'(base_word + {11'd0, tile_cnt[1:0]});
  assign issue_last = is_column ? (tile_cnt == COLUMN_LAST_TILE)
                                : (tile_cnt == SPRITE_LAST_TILE);

  // Sequencer next state and memory control.
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    ram_we_lo  = 1'b0;
    ram_we_hi  = 1'b0;
    ram_waddr  = AW'(mem_address[13:1]);
    ram_wdata  = mem_data;
    unique case (state)
      ST_CLEAR: begin
        ram_we_lo = 1'b1;
        ram_we_hi = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 8'd0;
        if (clr_cnt == AW'(HALF - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_WRITE) begin
            ram_we_lo = wr_in_range && !mem_address[0];
            ram_we_hi = wr_in_range && mem_address[0];
          end else if (!obj_empty) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
  assign ram_re    = issue;
  assign ram_raddr = AW'(tile_word);

  // State register and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= AW'(clr_cnt + 1'b1);
      end
    end
  end

  // Column position register.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_x <= 9'd0;
    end else if (accept && mode == MODE_OBJECT) begin
      column_x <= column_x_next;
    end
  end

  // Per-object context, latched at acceptance.
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_OBJECT) begin
      is_column  <= obj_code[7];
      base_word  <= obj_code[7] ? 13'(COLUMN_BASE_WORD + {1'b0, obj_code[5:0], 6'd0})
                                : {4'd0, obj_code[6:0], 2'd0};
      top_y      <= 8'((obj_code[7] ? COLUMN_TOP : SPRITE_TOP) - obj_y);
      attr_color <= obj_attr[3:0];
    end
  end

  // Tile counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_cnt <= 6'd0;
    end else if (accept) begin
      tile_cnt <= 6'd0;
    end else if (issue) begin
      tile_cnt <= 6'(tile_cnt + 1'b1);
    end
  end

  // Tile position alongside the memory read latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= issue_last;
      rd_xc   <= is_column ? tile_cnt[5] : tile_cnt[1];
      rd_yc   <= is_column ? tile_cnt[4:0] : {4'd0, tile_cnt[0]};
    end
  end

  // Descriptor low bytes at even addresses, high bytes at odd addresses.
  olt_ram #(.WIDTH(8), .DEPTH(HALF)) u_ram_lo (
    .clk   (clk),
    .we    (ram_we_lo),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (desc_lo)
  );

  olt_ram #(.WIDTH(8), .DEPTH(HALF)) u_ram_hi (
    .clk   (clk),
    .we    (ram_we_hi),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (desc_hi)
  );

  // Result beat formatting with wrap and optional mirror.
  assign x_raw        = 8'(column_x[7:0] + {4'd0, rd_xc, 3'd0});
  assign y_raw        = 8'(top_y + {rd_yc, 3'd0});
  assign result_valid = rd_valid;
  assign tile_code    = {desc_hi[5:0], desc_lo};
  assign tile_color   = {2'd0, desc_hi[7:6]} | attr_color;
  assign screen_x     = flip_screen ? 8'(FLIP_ORIGIN - x_raw) : x_raw;
  assign screen_y     = flip_screen ? 8'(FLIP_ORIGIN - y_raw) : y_raw;
  assign tile_flipped = flip_screen;
  assign last         = rd_last;

endmodule

[hdl/olt_checker.sv]
// Port-level checker for the object list tile generator, bound to the top level.
`timescale 1ns / 1ps

module olt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic mode,
  input logic result_valid,
  input logic last
);

  import olt_pkg::*;

  // A result beat always follows a cycle in which the block was busy.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  // Tiles of one object come out in consecutive cycles.
  a_tiles_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("gap inside the tile list of an object");

  // The cycle after the final tile carries no result.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result beat directly after the final tile");

  // A descriptor write completes in its own cycle.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_WRITE |=> !busy && !result_valid)
    else $error("descriptor write did not complete in one cycle");

endmodule

bind object_list_tile_generator olt_checker u_olt_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the object list tile generator.
`timescale 1ns / 1ps

module tb_top;
  import olt_pkg::*;

  localparam int MEM_BYTES = 16384;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int MAX_REPORTS = 40;

  // One command beat as presented on the input ports.
  typedef struct packed {
    logic        mode;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [7:0]  y;
    logic [7:0]  code;
    logic [7:0]  x;
    logic [7:0]  attr;
    logic        frame;
  } olt_cmd_t;

  // One tile as presented on the result ports.
  typedef struct packed {
    logic [13:0] code;
    logic [3:0]  color;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        flipped;
    logic        last;
  } olt_tile_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic        mode;
  logic [13:0] mem_address;
  logic [7:0]  mem_data;
  logic [7:0]  obj_y;
  logic [7:0]  obj_code;
  logic [7:0]  obj_x;
  logic [7:0]  obj_attr;
  logic        frame_start;
  logic        result_valid;
  logic [13:0] tile_code;
  logic [3:0]  tile_color;
  logic [7:0]  screen_x;
  logic [7:0]  screen_y;
  logic        tile_flipped;
  logic        last;

  // Local copy of the block state used for prediction.
  logic [7:0] desc_mem [MEM_BYTES];
  logic [8:0] col_x;
  logic       flip_on;

  olt_cmd_t  cmd_backlog[$];
  olt_tile_t tiles_due[$];
  int        beats_sent;
  int        beats_taken;
  int        idle_pct;
  int        errors;
  int        cycle_count;
  logic      took_beat;

  object_list_tile_generator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .mode(mode), .mem_address(mem_address),
    .mem_data(mem_data), .obj_y(obj_y), .obj_code(obj_code), .obj_x(obj_x),
    .obj_attr(obj_attr), .frame_start(frame_start),
    .result_valid(result_valid), .tile_code(tile_code), .tile_color(tile_color),
    .screen_x(screen_x), .screen_y(screen_y), .tile_flipped(tile_flipped),
    .last(last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the tiles of one accepted beat and update the local state.
  function automatic void predict_tiles(input olt_cmd_t c);
    int        base;
    int        height;
    int        a;
    logic [7:0] top;
    logic [7:0] lo;
    logic [7:0] hi;
    olt_tile_t t;
    if (c.mode == MODE_WRITE) begin
      desc_mem[c.addr] = c.data;
      return;
    end
    if (c.frame) col_x = '0;
    if (c.y == 8'd0 && c.code == 8'd0 && c.x == 8'd0 && c.attr == 8'd0) return;
    if (!c.code[7]) begin
      base = int'(c.code[6:0]) * 8;
      height = 2;
      col_x = {c.attr[6], c.x};
    end else begin
      base = int'(c.code[5:0]) * 128 + 'h400;
      height = 32;
      if (c.code[6]) col_x = col_x + 9'd16;
      else col_x = {c.attr[6], c.x};
    end
    top = 8'(256 - height * 8 - int'(c.y));
    for (int xc = 0; xc < 2; xc++) begin
      for (int yc = 0; yc < height; yc++) begin
        a = base + xc * height * 2 + yc * 2;
        lo = desc_mem[a];
        hi = desc_mem[a + 1];
        t.code = {hi[5:0], lo};
        t.color = {2'b00, hi[7:6]} | c.attr[3:0];
        t.x = col_x[7:0] + 8'(xc * 8);
        t.y = top + 8'(yc * 8);
        if (flip_on) begin
          t.x = FLIP_ORIGIN - t.x;
          t.y = FLIP_ORIGIN - t.y;
        end
        t.flipped = flip_on;
        t.last = (xc == 1 && yc == height - 1);
        tiles_due.push_back(t);
      end
    end
  endfunction

  // Report one field of a result beat that differs from its prediction.
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: take command beats into the predictor and check result beats.
  always @(posedge clk) begin
    olt_cmd_t  c;
    olt_tile_t w;
    took_beat <= !rst && start && !busy;
    if (!rst) begin
      if (result_valid) begin
        if (tiles_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected tile, expected none, actual code %0d x %0d y %0d",
                     $time, tile_code, screen_x, screen_y);
        end else begin
          w = tiles_due.pop_front();
          check_field("tile_code", w.code, tile_code);
          check_field("tile_color", w.color, tile_color);
          check_field("screen_x", w.x, screen_x);
          check_field("screen_y", w.y, screen_y);
          check_field("tile_flipped", w.flipped, tile_flipped);
          check_field("last", w.last, last);
        end
      end
      if (start && !busy) begin
        c = '{mode, mem_address, mem_data, obj_y, obj_code, obj_x, obj_attr, frame_start};
        predict_tiles(c);
        beats_taken <= beats_taken + 1;
      end
    end
  end

  // Driver: present the next pending command, with random idle gaps.
  always @(negedge clk) begin
    olt_cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_beat) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        c = cmd_backlog.pop_front();
        mode <= c.mode;
        mem_address <= c.addr;
        mem_data <= c.data;
        obj_y <= c.y;
        obj_code <= c.code;
        obj_x <= c.x;
        obj_attr <= c.attr;
        frame_start <= c.frame;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Queue a descriptor byte write.
  function automatic void queue_write(input int addr, input int data);
    olt_cmd_t c;
    c = '0;
    c.mode = MODE_WRITE;
    c.addr = 14'(addr);
    c.data = 8'(data);
    cmd_backlog.push_back(c);
    beats_sent++;
  endfunction

  // Queue an object entry.
  function automatic void queue_object(input int y, input int code, input int x,
                                       input int attr, input bit frame);
    olt_cmd_t c;
    c = '0;
    c.mode = MODE_OBJECT;
    c.y = 8'(y);
    c.code = 8'(code);
    c.x = 8'(x);
    c.attr = 8'(attr);
    c.frame = frame;
    cmd_backlog.push_back(c);
    beats_sent++;
  endfunction

  // Random traffic: descriptor writes aimed mostly at the areas that objects
  // read, objects drawn mostly from a small pool of indexes, and some noise.
  function automatic void queue_random(input int count);
    int pick;
    int code;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        pick = $urandom_range(99);
        if (pick < 50) queue_write($urandom_range(127), $urandom_range(255));
        else if (pick < 80) queue_write('h400 + $urandom_range(1023), $urandom_range(255));
        else queue_write($urandom_range(16383), $urandom_range(255));
      end else if (pick < 88) begin
        code = $urandom_range(255);
        if ($urandom_range(99) < 70) begin
          if ($urandom_range(99) < 60) code = $urandom_range(15);
          else code = 'h80 | ($urandom_range(1) << 6) | $urandom_range(7);
        end
        queue_object($urandom_range(255), code, $urandom_range(255), $urandom_range(255),
                     $urandom_range(99) < 15);
      end else if (pick < 94) begin
        queue_object(0, 0, 0, 0, $urandom_range(1));
      end else begin
        queue_object($urandom_range(1) * $urandom_range(255), 0, 0, 0, $urandom_range(1));
      end
    end
  endfunction

  // Register write over the configuration port: setup then access.
  task automatic write_flip(input logic value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_FLIP_SCREEN;
    pwdata <= {31'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    flip_on = value;
  endtask

  // Wait until every beat is taken and every tile has come back.
  task automatic wait_drained();
    while (beats_taken != beats_sent || tiles_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Stimulus sequence: reset, directed cases, then random phases.
  initial begin
    int idle_plan [4];
    logic flip_plan [4];
    idle_plan = '{0, 55, 0, 25};
    flip_plan = '{1'b0, 1'b1, 1'b1, 1'b0};
    for (int i = 0; i < MEM_BYTES; i++) desc_mem[i] = 8'd0;
    col_x = '0;
    flip_on = 1'b0;
    beats_sent = 0;
    beats_taken = 0;
    idle_pct = 0;
    errors = 0;
    cycle_count = 0;
    took_beat = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    mode = MODE_WRITE;
    mem_address = '0;
    mem_data = '0;
    obj_y = '0;
    obj_code = '0;
    obj_x = '0;
    obj_attr = '0;
    frame_start = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      write_flip(flip_plan[p]);
      idle_pct = idle_plan[p];
      if (p == 0) begin
        // Extremes of the descriptor bytes and addresses.
        queue_write(0, 'hff);
        queue_write(1, 'hff);
        queue_write(16383, 'haa);
        queue_write('h1fff, 'h12);
        queue_write(8, 'h00);
        queue_write(9, 'h80);
        // Sprites at the low and high ends of every object field.
        queue_object(0, 0, 0, 1, 1'b0);
        queue_object(255, 'h7f, 255, 'hff, 1'b0);
        queue_object(16, 1, 0, 'h40, 1'b0);
        // An empty object still clears the running column position.
        queue_object(0, 0, 0, 0, 1'b1);
        queue_object(0, 'hc0, 0, 0, 1'b0);
        queue_object(0, 0, 0, 0, 1'b0);
        // Columns: loaded position, chained columns, frame start, 9-bit wrap.
        queue_write('h400, 'h55);
        queue_write('h401, 'hc3);
        queue_object(0, 'h80, 'h10, 0, 1'b0);
        queue_object(7, 'hc0, 0, 0, 1'b0);
        queue_object(255, 'hff, 255, 'h4f, 1'b0);
        queue_object(3, 'hc1, 9, 2, 1'b1);
        queue_object(200, 'hbf, 'hff, 'h40, 1'b0);
        queue_object(1, 'hc0, 0, 0, 1'b0);
      end
      queue_random(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && tiles_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (tiles_due.size() != 0)
        $display("%0t: %0d tiles expected but never seen", $time, tiles_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[object_list_tile_generator.f]
hdl/olt_pkg.sv
hdl/olt_ram.sv
hdl/object_list_tile_generator.sv
hdl/olt_checker.sv
verif/tb_top.sv
